### rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

  // Field widths of one record and of the stream words.
  localparam int unsigned PRIO_W   = 3;
  localparam int unsigned LEVEL_W  = 2;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned SERVER_W = 8;
  localparam int unsigned LENGTH_W = 5;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 72;

  // Bit positions inside the input tdata word.
  localparam int unsigned IN_PRIO_LSB    = 0;
  localparam int unsigned IN_ARRIVAL_LSB = 3;
  localparam int unsigned IN_SERVICE_LSB = 19;
  localparam int unsigned IN_START_LSB   = 35;
  localparam int unsigned IN_SERVER_LSB  = 51;
  localparam int unsigned IN_FLAG_BIT    = 59;

  // Bit positions inside the output tdata word.
  localparam int unsigned OUT_PAYLOAD_W = 60;
  localparam int unsigned OUT_LENGTH_LSB = 60;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } spq_op_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } spq_status_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  level;
    logic [TICK_W-1:0]   arrival;
    logic [TICK_W-1:0]   service;
    logic [TICK_W-1:0]   start;
    logic [SERVER_W-1:0] server;
    logic                flag;
  } spq_rec_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic     ins;
    logic     rem;
    spq_rec_t rec;
  } spq_ctl_t;

  // Out-of-range priorities saturate into the four levels.
  function automatic logic [LEVEL_W-1:0] prio_to_level(input logic [PRIO_W-1:0] prio);
    logic [LEVEL_W-1:0] lvl;
    if (prio == PRIO_W'(0)) begin
      lvl = LEVEL_W'(0);
    end else if (prio >= PRIO_W'(4)) begin
      lvl = LEVEL_W'(3);
    end else begin
      lvl = LEVEL_W'(prio - PRIO_W'(1));
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

### rtl/spq_cell.sv
`default_nettype none

// One slot of the sorted chain. On insert, a slot that holds a record of
// equal or higher level keeps it; the first slot that does not takes the new
// record and every slot past it takes its left neighbor's record. On remove,
// every slot takes its right neighbor's record.
module spq_cell
  import spq_pkg::*;
(
  input  wire logic     clk,
  input  wire spq_ctl_t ctl,
  input  wire logic     occupied,
  input  wire logic     left_keep,
  input  wire spq_rec_t left_rec,
  input  wire spq_rec_t right_rec,
  output logic          keep,
  output spq_rec_t      rec
);

  assign keep = occupied && (rec.level >= ctl.rec.level);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (!keep) begin
        rec <= left_keep ? ctl.rec : left_rec;
      end
    end else if (ctl.rem) begin
      rec <= right_rec;
    end
  end

endmodule

`default_nettype wire

### rtl/stable_priority_queue_top.sv
`default_nettype none

// Channel  | Direction | Payload
// s_       | in        | tuser = func; tdata = request record
// m_       | out       | tuser = status; tdata = removed record and queue length
//
// Every accepted transaction is finished by one parallel update of all cells
// of the chain, so a new transaction can follow in the next cycle while
// s_tready stays high. The result sits in an output register; s_tready is
// high whenever that register is empty or is being emptied in the same cycle,
// so a stall on the master side stalls the slave side after one held result.
// Reset clears the record count and the output valid flag; the cell contents
// are not cleared, since only occupied cells are ever read.
module stable_priority_queue_top
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // priority_req[2:0], arrival_time[18:3], service_time[34:19],
  // start_time[50:35], server_index[58:51], flag_bit[59], zero fill
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // func[0]
  input  wire logic                  s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // out_priority[2:0], out_arrival_time[18:3], out_service_time[34:19],
  // out_start_time[50:35], out_server_index[58:51], out_flag_bit[59],
  // queue_length[64:60], zero fill
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // status[1:0]
  output logic [1:0]                 m_tuser
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > LENGTH_W) ? CW : LENGTH_W;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          accept;
  logic          full;
  logic          empty;
  spq_ctl_t      ctl;
  spq_status_t   status_next;
  logic [LW-1:0] length_wide;
  logic [OUT_DATA_W-1:0] m_tdata_next;

  spq_rec_t      cell_rec  [DEPTH];
  logic          cell_keep [DEPTH];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == CW'(0));

  // The incoming record, with its priority saturated to a two-bit level.
  always_comb begin
    ctl.rec.level   = prio_to_level(s_tdata[IN_PRIO_LSB +: PRIO_W]);
    ctl.rec.arrival = s_tdata[IN_ARRIVAL_LSB +: TICK_W];
    ctl.rec.service = s_tdata[IN_SERVICE_LSB +: TICK_W];
    ctl.rec.start   = s_tdata[IN_START_LSB +: TICK_W];
    ctl.rec.server  = s_tdata[IN_SERVER_LSB +: SERVER_W];
    ctl.rec.flag    = s_tdata[IN_FLAG_BIT];
    ctl.ins = accept && (s_tuser == OP_INSERT) && !full;
    ctl.rem = accept && (s_tuser == OP_REMOVE) && !empty;
  end

  // Cell zero sees an always-keeping neighbor on its left, so it takes the
  // new record whenever it does not keep its own. The last cell reloads its own
  // record on remove; that slot becomes unoccupied anyway.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (count > CW'(i)),
      .left_keep ((i == 0) ? 1'b1 : cell_keep[(i == 0) ? 0 : i - 1]),
      .left_rec  (cell_rec[(i == 0) ? 0 : i - 1]),
      .right_rec (cell_rec[(i == DEPTH - 1) ? i : i + 1]),
      .keep      (cell_keep[i]),
      .rec       (cell_rec[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctl.ins) begin
      count_next = count + CW'(1);
    end else if (ctl.rem) begin
      count_next = count - CW'(1);
    end
  end

  always_comb begin
    if (s_tuser == OP_INSERT) begin
      status_next = full ? ST_FULL : ST_INSERTED;
    end else begin
      status_next = empty ? ST_EMPTY : ST_REMOVED;
    end
  end

  // The reported length is the updated count wrapped to its five output bits.
  assign length_wide = LW'(count_next);

  // Result payload: the head record on a successful remove, zeros otherwise.
  always_comb begin
    m_tdata_next = '0;
    m_tdata_next[OUT_LENGTH_LSB +: LENGTH_W] = length_wide[LENGTH_W-1:0];
    if (ctl.rem) begin
      m_tdata_next[OUT_PAYLOAD_W-1:0] = {cell_rec[0].flag, cell_rec[0].server,
                                         cell_rec[0].start, cell_rec[0].service,
                                         cell_rec[0].arrival,
                                         PRIO_W'(cell_rec[0].level) + PRIO_W'(1)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tuser <= status_next;
      m_tdata <= m_tdata_next;
    end
  end

endmodule

`default_nettype wire

### rtl/spq_checker.sv
`default_nettype none

module spq_checker
  import spq_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic                  s_tuser,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic [1:0]            m_tuser
);

  // A held result keeps its data while the sink stalls.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Only a successful remove carries a record.
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_REMOVED) |-> (m_tdata[OUT_PAYLOAD_W-1:0] == '0))
    else $error("payload set without a removed record");

  // A removed record carries a priority of one to four.
  a_removed_prio: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_REMOVED) |->
      (m_tdata[PRIO_W-1:0] != PRIO_W'(0)) && (m_tdata[PRIO_W-1:0] <= PRIO_W'(4)))
    else $error("removed record with a bad priority");

  // An empty answer reports a queue length of zero.
  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_EMPTY) |-> (m_tdata[OUT_LENGTH_LSB +: LENGTH_W] == '0))
    else $error("empty status with nonzero length");

  // Every accepted request is answered in the next cycle; the upper status
  // bit tells a remove answer from an insert answer.
  a_answer: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid && (m_tuser[1] == $past(s_tuser)))
    else $error("request not answered with a matching status");

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
